// File: design/dd_pkg.sv
// dd_pkg: request/result payload types, controller/datapath command and status
// structs, controller states and calendar helpers. No dependencies.
`timescale 1ns / 1ps

package dd_pkg;

    localparam int unsigned K_YEAR_W     = 14;
    localparam int unsigned K_MONTH_W    = 4;
    localparam int unsigned K_DAY_W      = 5;
    localparam int unsigned K_COUNT_W    = 23;
    localparam int unsigned K_REM_W      = 9;    // holds year mod 400
    localparam int unsigned K_STEP_W     = 3;
    localparam int unsigned K_REDUCE_STEPS = 6;  // 400 << 5 .. 400 << 0

    localparam logic [K_YEAR_W:0]    K_LEAP_CYCLE  = 15'd400;
    localparam logic [K_REM_W-1:0]   K_REM_LAST    = 9'd399;
    localparam logic [K_MONTH_W-1:0] K_JANUARY     = 4'd1;
    localparam logic [K_MONTH_W-1:0] K_FEBRUARY    = 4'd2;
    localparam logic [K_MONTH_W-1:0] K_DECEMBER    = 4'd12;
    localparam logic [K_DAY_W-1:0]   K_FIRST_DAY   = 5'd1;
    localparam logic [K_COUNT_W-1:0] K_COUNT_LIMIT = 23'd4194303;

    typedef struct packed {
        logic [K_YEAR_W-1:0]  first_year;
        logic [K_MONTH_W-1:0] first_month;
        logic [K_DAY_W-1:0]   first_day;
        logic [K_YEAR_W-1:0]  second_year;
        logic [K_MONTH_W-1:0] second_month;
        logic [K_DAY_W-1:0]   second_day;
        logic                 include_end;
    } t_in;

    typedef struct packed {
        logic signed [K_COUNT_W-1:0] day_count;
        logic                        status;
    } t_out;

    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic walk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic reduce_last;
        logic invalid;
        logic walk_done;
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } t_state;

    // leap year from year mod 400
    function automatic logic is_leap(input logic [K_REM_W-1:0] rem);
        logic hundred;
        hundred = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
        return (rem[1:0] == 2'b00) && !hundred;
    endfunction

    // month length; 0 for a month code outside 1..12
    function automatic logic [K_DAY_W-1:0] days_in(input logic [K_MONTH_W-1:0] month,
                                                   input logic leap);
        logic [K_DAY_W-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            K_FEBRUARY:                                 len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: design/dd_ctrl.sv
// dd_ctrl: sequencing state machine for the date difference block.
// Depends on dd_pkg (t_state, t_cmd, t_sts).
`timescale 1ns / 1ps

module dd_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  dd_pkg::t_sts i_sts,
    output logic         o_in_stall,
    output dd_pkg::t_cmd o_cmd
);

    dd_pkg::t_state r_state;
    dd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            dd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dd_pkg::ST_REDUCE;
                end
            end
            dd_pkg::ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_sts.reduce_last) begin
                    n_state = dd_pkg::ST_CHECK;
                end
            end
            dd_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.invalid ? dd_pkg::ST_DONE : dd_pkg::ST_WALK;
            end
            dd_pkg::ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = dd_pkg::ST_DONE;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            dd_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = dd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/dd_datapath.sv
// dd_datapath: request register, year mod 400 reduction, date check,
// day-by-day walk, result register. Depends on dd_pkg.
`timescale 1ns / 1ps

module dd_datapath #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  dd_pkg::t_cmd i_cmd,
    input  dd_pkg::t_in  i_in_data,
    input  logic         i_out_stall,
    output dd_pkg::t_sts o_sts,
    output logic         o_out_valid,
    output dd_pkg::t_out o_out_data
);

    localparam logic [dd_pkg::K_YEAR_W-1:0] LP_MAX_YEAR = dd_pkg::K_YEAR_W'(MAX_YEAR);

    dd_pkg::t_in                       r_req;
    logic [dd_pkg::K_YEAR_W-1:0]       r_rem1;
    logic [dd_pkg::K_YEAR_W-1:0]       r_rem2;
    logic [dd_pkg::K_STEP_W-1:0]       r_step;

    logic [dd_pkg::K_YEAR_W-1:0]       r_walk_year;
    logic [dd_pkg::K_MONTH_W-1:0]      r_walk_month;
    logic [dd_pkg::K_DAY_W-1:0]        r_walk_day;
    logic [dd_pkg::K_REM_W-1:0]        r_walk_rem;
    logic [dd_pkg::K_YEAR_W-1:0]       r_tgt_year;
    logic [dd_pkg::K_MONTH_W-1:0]      r_tgt_month;
    logic [dd_pkg::K_DAY_W-1:0]        r_tgt_day;
    logic [dd_pkg::K_COUNT_W-1:0]      r_day_counter;
    logic                              r_negate;
    logic                              r_invalid;

    dd_pkg::t_out                      r_out;
    logic                              r_out_valid;

    // reduction step
    logic [dd_pkg::K_YEAR_W:0] sub_val;
    logic [dd_pkg::K_YEAR_W:0] diff1;
    logic [dd_pkg::K_YEAR_W:0] diff2;

    // date check
    logic leap1, leap2, ok1, ok2, neg;

    // walk step
    logic [dd_pkg::K_DAY_W-1:0] month_len;
    logic                       walk_done;

    // finish
    logic [dd_pkg::K_COUNT_W-1:0] mag;
    logic [dd_pkg::K_COUNT_W-1:0] mag_sat;

    always_comb begin
        sub_val = dd_pkg::K_LEAP_CYCLE << r_step;
        diff1   = {1'b0, r_rem1} - sub_val;
        diff2   = {1'b0, r_rem2} - sub_val;
    end

    always_comb begin
        leap1 = dd_pkg::is_leap(r_rem1[dd_pkg::K_REM_W-1:0]);
        leap2 = dd_pkg::is_leap(r_rem2[dd_pkg::K_REM_W-1:0]);
        ok1 = (r_req.first_year != '0) && (r_req.first_year <= LP_MAX_YEAR)
            && (r_req.first_day != '0)
            && (r_req.first_day <= dd_pkg::days_in(r_req.first_month, leap1));
        ok2 = (r_req.second_year != '0) && (r_req.second_year <= LP_MAX_YEAR)
            && (r_req.second_day != '0)
            && (r_req.second_day <= dd_pkg::days_in(r_req.second_month, leap2));
        neg = {r_req.first_year, r_req.first_month, r_req.first_day}
            > {r_req.second_year, r_req.second_month, r_req.second_day};
    end

    always_comb begin
        month_len = dd_pkg::days_in(r_walk_month, dd_pkg::is_leap(r_walk_rem));
        walk_done = (r_walk_year == r_tgt_year) && (r_walk_month == r_tgt_month)
                 && (r_walk_day == r_tgt_day);
    end

    always_comb begin
        mag     = r_day_counter + dd_pkg::K_COUNT_W'(r_req.include_end);
        mag_sat = (mag > dd_pkg::K_COUNT_LIMIT) ? dd_pkg::K_COUNT_LIMIT : mag;
    end

    always_comb begin
        o_sts.reduce_last = (r_step == '0);
        o_sts.invalid     = !(ok1 && ok2);
        o_sts.walk_done   = walk_done;
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    // payload side
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in_data;
            r_rem1 <= i_in_data.first_year;
            r_rem2 <= i_in_data.second_year;
            r_step <= dd_pkg::K_STEP_W'(dd_pkg::K_REDUCE_STEPS - 1);
        end else if (i_cmd.reduce) begin
            if (!diff1[dd_pkg::K_YEAR_W]) begin
                r_rem1 <= diff1[dd_pkg::K_YEAR_W-1:0];
            end
            if (!diff2[dd_pkg::K_YEAR_W]) begin
                r_rem2 <= diff2[dd_pkg::K_YEAR_W-1:0];
            end
            r_step <= r_step - 1'b1;
        end
        if (i_cmd.check) begin
            r_invalid <= !(ok1 && ok2);
        end
        if (i_cmd.finish) begin
            if (r_invalid) begin
                r_out.day_count <= '0;
                r_out.status    <= 1'b1;
            end else begin
                r_out.day_count <= r_negate ? -$signed(mag_sat) : $signed(mag_sat);
                r_out.status    <= 1'b0;
            end
        end
    end

    // walk state; unchanged by an invalid request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_year   <= '0;
            r_walk_month  <= dd_pkg::K_JANUARY;
            r_walk_day    <= dd_pkg::K_FIRST_DAY;
            r_walk_rem    <= '0;
            r_day_counter <= '0;
            r_negate      <= 1'b0;
            r_tgt_year    <= '0;
            r_tgt_month   <= dd_pkg::K_JANUARY;
            r_tgt_day     <= dd_pkg::K_FIRST_DAY;
        end else if (i_cmd.check && ok1 && ok2) begin
            r_negate      <= neg;
            r_day_counter <= '0;
            if (neg) begin
                r_walk_year  <= r_req.second_year;
                r_walk_month <= r_req.second_month;
                r_walk_day   <= r_req.second_day;
                r_walk_rem   <= r_rem2[dd_pkg::K_REM_W-1:0];
                r_tgt_year   <= r_req.first_year;
                r_tgt_month  <= r_req.first_month;
                r_tgt_day    <= r_req.first_day;
            end else begin
                r_walk_year  <= r_req.first_year;
                r_walk_month <= r_req.first_month;
                r_walk_day   <= r_req.first_day;
                r_walk_rem   <= r_rem1[dd_pkg::K_REM_W-1:0];
                r_tgt_year   <= r_req.second_year;
                r_tgt_month  <= r_req.second_month;
                r_tgt_day    <= r_req.second_day;
            end
        end else if (i_cmd.walk) begin
            r_day_counter <= r_day_counter + 1'b1;
            if (r_walk_day == month_len) begin
                r_walk_day <= dd_pkg::K_FIRST_DAY;
                if (r_walk_month == dd_pkg::K_DECEMBER) begin
                    r_walk_month <= dd_pkg::K_JANUARY;
                    r_walk_year  <= r_walk_year + 1'b1;
                    r_walk_rem   <= (r_walk_rem == dd_pkg::K_REM_LAST) ? '0
                                                                       : r_walk_rem + 1'b1;
                end else begin
                    r_walk_month <= r_walk_month + 1'b1;
                end
            end else begin
                r_walk_day <= r_walk_day + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/date_difference_in_days_top.sv
// Date difference block, top level: joins dd_ctrl and dd_datapath.
// Depends on dd_pkg, dd_ctrl, dd_datapath.
`timescale 1ns / 1ps

// Gives the signed number of days from a first Gregorian date to a second.
// A request carries both dates (year, month, day) and an include-end flag.
// The earlier date is stepped one calendar day per clock until it meets the
// later one; the count is negated when the first date is the later one, and
// include-end adds one day before the sign. Equal dates give 0, or 1 with
// include-end. A year of 0 or above MAX_YEAR, a month outside 1..12 or a day
// outside the month gives status 1 and a count of 0. Counts beyond the
// 23-bit signed range (only possible with a raised MAX_YEAR) saturate at
// +/-4194303. Timing: one request at a time. From acceptance, the request
// passes the year mod 400 reduction, the check, the day walk over the day
// distance between the dates and the walk's final compare before the result
// register is loaded; an invalid request skips the walk. The hand-off also
// waits while the previous result still sits in the output register. Input
// stall drops as soon as the result sits in the output register, so the
// next request is taken while that result still waits to be drained.

module date_difference_in_days_top #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request channel
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  dd_pkg::t_in  i_in_data,
    // result channel
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output dd_pkg::t_out o_out_data
);

    dd_pkg::t_cmd cmd;
    dd_pkg::t_sts sts;

    // sequencing: idle, reduce years, check, walk, hand off
    dd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // all request, walk and result storage
    dd_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: design/dd_checker.sv
// dd_checker: port-level checks on the date difference block, bound to the top.
// Depends on dd_pkg and date_difference_in_days_top.
`timescale 1ns / 1ps

module dd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         o_in_stall,
    input dd_pkg::t_in  i_in_data,
    input logic         o_out_valid,
    input logic         i_out_stall,
    input dd_pkg::t_out o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while busy");

    // a new result only comes from a request in progress
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in progress");

    // an invalid date forces a zero count
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |-> (o_out_data.day_count == '0))
        else $error("invalid result with nonzero count");

endmodule

bind date_difference_in_days_top dd_checker u_dd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: dv/tb_date_difference_in_days_top.sv
// Testbench for date_difference_in_days_top: directed and random date pairs,
// checked against a day-count scoreboard. Depends on dd_pkg and the top level.
`timescale 1ns / 1ps

localparam int unsigned YEAR_LIMIT    = 9999;
localparam int unsigned COUNT_CEILING = 4194303;
localparam bit          STATUS_OK       = 1'b0;
localparam bit          STATUS_BAD_DATE = 1'b1;

typedef enum int unsigned {
    MON_JAN = 1, MON_FEB = 2, MON_MAR = 3, MON_APR = 4, MON_DEC = 12
} month_e;

typedef enum int unsigned {
    FLAW_YEAR_ZERO,
    FLAW_YEAR_HIGH,
    FLAW_MONTH,
    FLAW_DAY_ZERO,
    FLAW_DAY_PAST_END
} date_flaw_e;

function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
endfunction

// days in month m of year y; 0 for a month code outside 1..12
function automatic int unsigned month_days(int unsigned m, int unsigned y);
    case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        MON_FEB:               return leap_year(y) ? 29 : 28;
        default:               return 0;
    endcase
endfunction

// Holds the day counts owed by the block, oldest first.
class date_diff_board;
    dd_pkg::t_out pending_counts[$];
    int unsigned  mismatches;

    function new();
        mismatches = 0;
    endfunction

    function bit date_ok(int unsigned y, int unsigned m, int unsigned d);
        return (y >= 1) && (y <= YEAR_LIMIT) && (m >= 1) && (m <= 12) &&
               (d >= 1) && (d <= month_days(m, y));
    endfunction

    // days since 1 January of year 1
    function int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
        return n + d - 1;
    endfunction

    function dd_pkg::t_out predict_day_count(dd_pkg::t_in r);
        dd_pkg::t_out res;
        int unsigned  a;
        int unsigned  b;
        int unsigned  mag;
        int           signed_mag;
        bit           neg;
        res.day_count = '0;
        res.status    = STATUS_BAD_DATE;
        if (!date_ok(r.first_year, r.first_month, r.first_day) ||
            !date_ok(r.second_year, r.second_month, r.second_day)) begin
            return res;
        end
        a   = day_number(r.first_year, r.first_month, r.first_day);
        b   = day_number(r.second_year, r.second_month, r.second_day);
        neg = a > b;
        mag = (neg ? a - b : b - a) + r.include_end;
        if (mag > COUNT_CEILING) mag = COUNT_CEILING;
        signed_mag    = neg ? -int'(mag) : int'(mag);
        res.day_count = signed_mag[dd_pkg::K_COUNT_W-1:0];
        res.status    = STATUS_OK;
        return res;
    endfunction

    function void note_request(dd_pkg::t_in r);
        pending_counts.push_back(predict_day_count(r));
    endfunction

    function void check_result(dd_pkg::t_out got);
        dd_pkg::t_out want;
        if (pending_counts.size() == 0) begin
            $display("%0t: result with no request outstanding, day_count %0d status %0d",
                     $time, $signed(got.day_count), got.status);
            mismatches++;
            return;
        end
        want = pending_counts.pop_front();
        if (got.day_count !== want.day_count) begin
            $display("%0t: day_count expected %0d got %0d", $time,
                     $signed(want.day_count), $signed(got.day_count));
            mismatches++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            mismatches++;
        end
    endfunction
endclass

module tb_date_difference_in_days_top;

    // Slowest sane run: ~125 requests of at most ~8000 walked days each, plus
    // sender gaps, receiver stalls and the forced hold. Taken several times.
    localparam int unsigned CYCLE_LIMIT   = 4000000;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned RANDOM_COUNT  = 100;
    localparam int unsigned PRESSURE_HOLD = 300;
    localparam int unsigned DRAIN_CYCLES  = 20;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    dd_pkg::t_in   in_data = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    dd_pkg::t_out  out_data;

    date_diff_board board;
    int unsigned    cycle_count = 0;
    bit             steady      = 1'b0;  // no gaps and no stalls on either side
    bit             hold_asked  = 1'b0;  // receiver takes one long hold-off

    date_difference_in_days_top #(
        .MAX_YEAR(YEAR_LIMIT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung walk or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic dd_pkg::t_in date_pair(int unsigned y1, int unsigned m1,
                                              int unsigned d1, int unsigned y2,
                                              int unsigned m2, int unsigned d2,
                                              bit inc);
        dd_pkg::t_in r;
        r.first_year   = 14'(y1);
        r.first_month  = 4'(m1);
        r.first_day    = 5'(d1);
        r.second_year  = 14'(y2);
        r.second_month = 4'(m2);
        r.second_day   = 5'(d2);
        r.include_end  = inc;
        return r;
    endfunction

    // Called in the time step of a rising edge. Valid is touched once per step:
    // either lowered for a gap or kept high with the next request.
    task automatic send_request(input dd_pkg::t_in req);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.note_request(req);
    endtask

    // Result side: checks every accepted result, stalls at random, and takes
    // the one long hold-off when asked so that the block backs up.
    initial begin : result_sink
        int unsigned hold;
        bit          hold_taken;
        hold       = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_valid && !out_stall) board.check_result(out_data);
            if (hold_asked && !hold_taken) begin
                hold       = PRESSURE_HOLD;
                hold_taken = 1'b1;
            end
            if (hold == 0) hold = idle_cycles();
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : request_source
        dd_pkg::t_in r;
        int unsigned pick;
        int          y2;
        int unsigned m2;
        date_flaw_e  flaw;

        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: equal dates, both include-end settings, calendar edges.
        send_request(date_pair(2024, MON_FEB, 29, 2024, MON_FEB, 29, 1'b0));
        send_request(date_pair(2024, MON_FEB, 29, 2024, MON_FEB, 29, 1'b1));
        send_request(date_pair(1, MON_JAN, 1, 1, MON_JAN, 2, 1'b0));
        send_request(date_pair(1, MON_JAN, 1, 1, MON_DEC, 31, 1'b1));
        send_request(date_pair(YEAR_LIMIT, MON_DEC, 31, YEAR_LIMIT, MON_DEC, 30, 1'b1));
        send_request(date_pair(YEAR_LIMIT, 6, 15, 9990, MON_FEB, 1, 1'b0));
        send_request(date_pair(2000, MON_FEB, 28, 2000, MON_MAR, 1, 1'b0));   // 400 rule
        send_request(date_pair(1900, MON_FEB, 28, 1900, MON_MAR, 1, 1'b0));   // century
        send_request(date_pair(2400, MON_FEB, 29, 2400, MON_MAR, 1, 1'b0));
        send_request(date_pair(2023, MON_DEC, 31, 2024, MON_JAN, 1, 1'b1));  // year wrap
        send_request(date_pair(2024, MON_MAR, 1, 2024, MON_FEB, 28, 1'b0));   // first later
        send_request(date_pair(1899, MON_DEC, 31, 1901, MON_JAN, 1, 1'b1));
        // Directed: each way a date can be malformed.
        send_request(date_pair(0, MON_JAN, 1, 1, MON_JAN, 1, 1'b0));
        send_request(date_pair(2000, MON_JAN, 1, YEAR_LIMIT + 1, MON_JAN, 1, 1'b1));
        send_request(date_pair(2000, MON_JAN, 1, 16383, 15, 31, 1'b0));
        send_request(date_pair(2000, 0, 1, 2000, MON_JAN, 1, 1'b0));
        send_request(date_pair(2000, MON_JAN, 1, 2000, 13, 1, 1'b0));
        send_request(date_pair(2000, 15, 1, 2000, MON_JAN, 1, 1'b1));
        send_request(date_pair(2000, MON_JAN, 0, 2000, MON_JAN, 1, 1'b0));
        send_request(date_pair(2000, MON_APR, 31, 2000, MON_APR, 30, 1'b0));
        send_request(date_pair(2023, MON_FEB, 29, 2023, MON_MAR, 1, 1'b0));
        send_request(date_pair(1900, MON_MAR, 1, 1900, MON_FEB, 29, 1'b0));
        send_request(date_pair(2000, MON_FEB, 30, 2000, MON_MAR, 1, 1'b1));

        // Random: mostly nearby valid pairs, a few far apart, some malformed.
        for (int unsigned idx = 0; idx < RANDOM_COUNT; idx++) begin
            if (idx == 40) hold_asked = 1'b1;
            steady = (idx >= 60) && (idx < 75);

            r.first_year  = 14'($urandom_range(1, YEAR_LIMIT));
            r.first_month = 4'($urandom_range(1, 12));
            r.first_day   = 5'($urandom_range(1, month_days(r.first_month, r.first_year)));
            r.include_end = 1'($urandom_range(0, 1));
            // short walks while the receiver holds off, so the block backs up
            pick = (idx >= 40 && idx < 56) ? 0 : $urandom_range(0, 99);
            y2 = int'(r.first_year);
            m2 = r.first_month;
            if (pick >= 50) m2 = $urandom_range(1, 12);
            if (pick >= 75 && pick < 88) y2 += $urandom_range(0, 1) ? 1 : -1;
            if (pick >= 88 && pick < 92) begin
                y2 += $urandom_range(0, 1) ? int'($urandom_range(2, 20))
                                           : -int'($urandom_range(2, 20));
            end
            if (y2 < 1 || y2 > int'(YEAR_LIMIT)) y2 = int'(r.first_year);
            r.second_year  = 14'(y2);
            r.second_month = 4'(m2);
            r.second_day   = 5'($urandom_range(1, month_days(m2, y2)));

            if (pick >= 92) begin
                flaw = date_flaw_e'($urandom_range(0, FLAW_DAY_PAST_END));
                if ($urandom_range(0, 1)) begin
                    case (flaw)
                        FLAW_YEAR_ZERO: r.first_year = '0;
                        FLAW_YEAR_HIGH: r.first_year = 14'($urandom_range(YEAR_LIMIT + 1, 16383));
                        FLAW_MONTH: begin
                            r.first_month = $urandom_range(0, 1) ? 4'd0
                                                                 : 4'($urandom_range(13, 15));
                        end
                        FLAW_DAY_ZERO: r.first_day = '0;
                        default: begin
                            r.first_month = 4'(MON_FEB);
                            r.first_day   = 5'($urandom_range(
                                month_days(MON_FEB, r.first_year) + 1, 31));
                        end
                    endcase
                end else begin
                    case (flaw)
                        FLAW_YEAR_ZERO: r.second_year = '0;
                        FLAW_YEAR_HIGH: r.second_year = 14'($urandom_range(YEAR_LIMIT + 1, 16383));
                        FLAW_MONTH: begin
                            r.second_month = $urandom_range(0, 1) ? 4'd0
                                                                  : 4'($urandom_range(13, 15));
                        end
                        FLAW_DAY_ZERO: r.second_day = '0;
                        default: begin
                            r.second_month = 4'(MON_FEB);
                            r.second_day   = 5'($urandom_range(
                                month_days(MON_FEB, r.second_year) + 1, 31));
                        end
                    endcase
                end
            end
            send_request(r);
        end
        steady = 1'b0;

        // Drain: every owed count must arrive, then a short quiet spell.
        in_valid <= 1'b0;
        while (board.pending_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
